@@ design/mbba_pkg.sv @@
// ---------------------------------------------------------------------------
// mbba_pkg
// Shared types and codes for the multi-block bump allocator: command and
// status codes, controller states and the controller/datapath interface.
// ---------------------------------------------------------------------------
package mbba_pkg;

    localparam int GROWTH_W         = 32;
    localparam int MIN_BLOCK_RESET  = 4096;

    typedef logic [1:0] t_cmd_code;
    localparam t_cmd_code CMD_TAKE    = 2'd0;
    localparam t_cmd_code CMD_RELEASE = 2'd1;
    localparam t_cmd_code CMD_RESET   = 2'd2;
    localparam t_cmd_code CMD_NOP     = 2'd3;

    typedef logic [1:0] t_status_code;
    localparam t_status_code ST_OK       = 2'd0;
    localparam t_status_code ST_FULL     = 2'd1;
    localparam t_status_code ST_OVERFLOW = 2'd2;
    localparam t_status_code ST_BAD_MARK = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_EXEC = 5'b00100,
        S_SUM  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the input beat
        logic exec;      // apply the command, clear the used-byte sum
        logic sum_step;  // walk the block table one entry per cycle
        logic load_out;  // move the result into the output register
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic sum_done;
    } t_dp_status;

endpackage

@@ design/multi_block_bump_allocator_top.sv @@
// ---------------------------------------------------------------------------
// multi_block_bump_allocator_top
// Bump-pointer arena over a bounded chain of blocks, with take, release to
// mark and arena reset commands, one result beat per command beat.
// ---------------------------------------------------------------------------
// Usage:
//   Command beats enter on i_valid/o_ready, result beats leave on
//   o_valid/i_ready. Every command beat gives exactly one result beat.
//   min_block_bytes is written through i_cfg_wr_en/i_cfg_wr_data while idle.
// Timing:
//   One command at a time. After acceptance a command passes through a
//   table read and an execute state; then the used byte count adds one
//   block size a cycle from the single read port of the block table, for
//   the blocks before the current one, and the result is loaded. The next
//   command can be accepted in the cycle after the load.
// Reset:
//   Synchronous reset empties the chain, clears pointers, counters and the
//   high-water mark and sets min_block_bytes to 4096. No clearing pass.
// Stall:
//   A finished result waits in the output register while i_ready is low;
//   the next command can be accepted meanwhile, and its result is held
//   back until the output register frees.
// ---------------------------------------------------------------------------
module multi_block_bump_allocator_top #(
    parameter int MAX_BLOCKS = 8,
    parameter int BYTE_BITS  = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [BYTE_BITS-1:0]          i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_command,
    input  logic [BYTE_BITS-1:0]          i_size_bytes,
    input  logic [3:0]                    i_align_log2,
    input  logic [$clog2(MAX_BLOCKS)-1:0] i_mark_block,
    input  logic [BYTE_BITS-1:0]          i_mark_offset,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic [$clog2(MAX_BLOCKS)-1:0] o_block_index,
    output logic [BYTE_BITS-1:0]          o_grant_offset,
    output logic                          o_grew,
    output logic [BYTE_BITS-1:0]          o_used_sum,
    output logic [BYTE_BITS-1:0]          o_high_water,
    output logic [BYTE_BITS-1:0]          o_capacity,
    output logic [mbba_pkg::GROWTH_W-1:0] o_growth_count
);
    import mbba_pkg::*;

    t_ctl_cmd   w_ctl_cmd;
    t_dp_status w_dp_status;

    mbba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .i_dp_status (w_dp_status),
        .o_ctl_cmd   (w_ctl_cmd)
    );

    mbba_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .BYTE_BITS  (BYTE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl_cmd      (w_ctl_cmd),
        .o_dp_status    (w_dp_status),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_command      (i_command),
        .i_size_bytes   (i_size_bytes),
        .i_align_log2   (i_align_log2),
        .i_mark_block   (i_mark_block),
        .i_mark_offset  (i_mark_offset),
        .o_status       (o_status),
        .o_block_index  (o_block_index),
        .o_grant_offset (o_grant_offset),
        .o_grew         (o_grew),
        .o_used_sum     (o_used_sum),
        .o_high_water   (o_high_water),
        .o_capacity     (o_capacity),
        .o_growth_count (o_growth_count)
    );

endmodule

@@ design/mbba_ctrl.sv @@
// ---------------------------------------------------------------------------
// mbba_ctrl
// Controller for the bump allocator: sequences read, execute, used-byte
// summation and result hand-off, and owns the output valid flag.
// ---------------------------------------------------------------------------
module mbba_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    output logic                 o_valid,
    input  logic                 i_ready,
    input  mbba_pkg::t_dp_status i_dp_status,
    output mbba_pkg::t_ctl_cmd   o_ctl_cmd
);
    import mbba_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_load;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    // result register is free when empty or its beat leaves this cycle
    assign w_load  = (r_state == S_DONE) && (!r_out_valid || i_ready);

    always_comb begin
        o_ctl_cmd          = '0;
        o_ctl_cmd.capture  = (r_state == S_IDLE) && i_valid;
        o_ctl_cmd.exec     = (r_state == S_EXEC);
        o_ctl_cmd.sum_step = (r_state == S_SUM);
        o_ctl_cmd.load_out = w_load;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_READ;
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                if (i_dp_status.sum_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl_cmd.load_out |-> (!r_out_valid || i_ready))
        else $error("result register overwritten while held");

endmodule

@@ design/mbba_dp.sv @@
// ---------------------------------------------------------------------------
// mbba_dp
// Datapath for the bump allocator: block size table, arena pointers,
// alignment and fit logic, serial used-byte sum and the result register.
// ---------------------------------------------------------------------------
module mbba_dp #(
    parameter int MAX_BLOCKS = 8,
    parameter int BYTE_BITS  = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mbba_pkg::t_ctl_cmd                 i_ctl_cmd,
    output mbba_pkg::t_dp_status               o_dp_status,
    input  logic                               i_cfg_wr_en,
    input  logic [BYTE_BITS-1:0]               i_cfg_wr_data,
    input  logic [1:0]                         i_command,
    input  logic [BYTE_BITS-1:0]               i_size_bytes,
    input  logic [3:0]                         i_align_log2,
    input  logic [$clog2(MAX_BLOCKS)-1:0]      i_mark_block,
    input  logic [BYTE_BITS-1:0]               i_mark_offset,
    output logic [1:0]                         o_status,
    output logic [$clog2(MAX_BLOCKS)-1:0]      o_block_index,
    output logic [BYTE_BITS-1:0]               o_grant_offset,
    output logic                               o_grew,
    output logic [BYTE_BITS-1:0]               o_used_sum,
    output logic [BYTE_BITS-1:0]               o_high_water,
    output logic [BYTE_BITS-1:0]               o_capacity,
    output logic [mbba_pkg::GROWTH_W-1:0]      o_growth_count
);
    import mbba_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CW    = $clog2(MAX_BLOCKS + 1);
    // room for offset plus alignment plus size without wrap
    localparam int AW    = ((BYTE_BITS > 16) ? BYTE_BITS : 16) + 2;

    // block size table
    logic [BYTE_BITS-1:0] r_mem [MAX_BLOCKS];
    logic [BYTE_BITS-1:0] r_rd_data;
    logic [IDX_W-1:0]     w_rd_addr;
    logic                 w_mem_we;
    logic [IDX_W-1:0]     w_mem_waddr;
    logic [BYTE_BITS-1:0] w_mem_wdata;

    // captured beat
    t_cmd_code            r_cmd;
    logic [BYTE_BITS-1:0] r_size;
    logic [3:0]           r_alog;
    logic [IDX_W-1:0]     r_mblk;
    logic [BYTE_BITS-1:0] r_moff;

    // arena state
    logic [CW-1:0]        r_count, n_count;
    logic [IDX_W-1:0]     r_cur, n_cur;
    logic [BYTE_BITS-1:0] r_off, n_off;
    logic [BYTE_BITS-1:0] r_total, n_total;
    logic [GROWTH_W-1:0]  r_growths, n_growths;
    logic [BYTE_BITS-1:0] r_peak, n_peak;
    logic [BYTE_BITS-1:0] r_min;

    // per-command result
    t_status_code         r_res_status, n_res_status;
    logic [BYTE_BITS-1:0] r_grant, n_grant;
    logic                 r_grew, n_grew;
    logic                 r_take_ok, n_take_ok;

    // used-byte sum
    logic [IDX_W-1:0]     r_sum_idx;
    logic                 r_sum_pend;
    logic [BYTE_BITS-1:0] r_acc;
    logic [BYTE_BITS-1:0] w_used;

    // output register
    t_status_code         r_o_status;
    logic [IDX_W-1:0]     r_o_block;
    logic [BYTE_BITS-1:0] r_o_grant;
    logic                 r_o_grew;
    logic [BYTE_BITS-1:0] r_o_used;
    logic [BYTE_BITS-1:0] r_o_peak;
    logic [BYTE_BITS-1:0] r_o_cap;
    logic [GROWTH_W-1:0]  r_o_growths;

    // take arithmetic
    logic [AW-1:0] w_mask, w_align, w_am1, w_off_x, w_at, w_end, w_size_x, w_rd_x;
    logic [AW-1:0] w_want0, w_want1, w_want, w_tot_x, w_min_x, w_tot_sum;
    logic          w_fit, w_full, w_ovf, w_good;

    assign w_mask    = {{(AW - BYTE_BITS){1'b0}}, {BYTE_BITS{1'b1}}};
    assign w_align   = AW'(1) << r_alog;
    assign w_am1     = w_align - AW'(1);
    assign w_off_x   = AW'(r_off);
    assign w_size_x  = AW'(r_size);
    assign w_rd_x    = AW'(r_rd_data);
    assign w_tot_x   = AW'(r_total);
    assign w_min_x   = AW'(r_min);
    assign w_at      = (w_off_x + w_am1) & ~w_am1;
    assign w_end     = w_at + w_size_x;
    assign w_fit     = (r_count != '0) && (w_end <= w_rd_x);
    assign w_want0   = w_size_x + w_align;
    assign w_want1   = (w_tot_x > w_want0) ? w_tot_x : w_want0;
    assign w_want    = (w_min_x > w_want1) ? w_min_x : w_want1;
    assign w_tot_sum = w_tot_x + w_want;
    assign w_full    = (r_count == CW'(MAX_BLOCKS));
    assign w_ovf     = (w_want > w_mask) || (w_tot_sum > w_mask);

    // with an empty table only the mark at the very start is good
    always_comb begin
        if (r_count == '0) begin
            w_good = (r_mblk == '0) && (r_moff == '0);
        end else begin
            w_good = (CW'(r_mblk) < r_count) && (r_moff <= r_rd_data);
        end
    end

    always_comb begin
        n_count      = r_count;
        n_cur        = r_cur;
        n_off        = r_off;
        n_total      = r_total;
        n_growths    = r_growths;
        n_res_status = ST_OK;
        n_grant      = '0;
        n_grew       = 1'b0;
        n_take_ok    = 1'b0;
        w_mem_we     = 1'b0;
        w_mem_waddr  = '0;
        w_mem_wdata  = r_total;
        case (r_cmd)
            CMD_TAKE: begin
                if (w_fit) begin
                    n_off     = w_end[BYTE_BITS-1:0];
                    n_grant   = w_at[BYTE_BITS-1:0];
                    n_take_ok = 1'b1;
                end else if (w_full) begin
                    n_res_status = ST_FULL;
                end else if (w_ovf) begin
                    n_res_status = ST_OVERFLOW;
                end else begin
                    w_mem_we    = 1'b1;
                    w_mem_waddr = r_count[IDX_W-1:0];
                    w_mem_wdata = w_want[BYTE_BITS-1:0];
                    n_cur       = r_count[IDX_W-1:0];
                    n_count     = r_count + CW'(1);
                    n_total     = w_tot_sum[BYTE_BITS-1:0];
                    if (r_growths != '1) n_growths = r_growths + GROWTH_W'(1);
                    n_off       = r_size;
                    n_grew      = 1'b1;
                    n_take_ok   = 1'b1;
                end
            end
            CMD_RELEASE: begin
                if (w_good) begin
                    n_cur = r_mblk;
                    n_off = r_moff;
                end else begin
                    n_res_status = ST_BAD_MARK;
                end
            end
            CMD_RESET: begin
                n_cur = '0;
                n_off = '0;
                // fold the chain into one block of the whole capacity
                if (r_count > CW'(1)) begin
                    w_mem_we    = 1'b1;
                    w_mem_waddr = '0;
                    w_mem_wdata = r_total;
                    n_count     = CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign w_rd_addr = i_ctl_cmd.sum_step ? r_sum_idx
                     : ((r_cmd == CMD_RELEASE) ? r_mblk : r_cur);

    always_ff @(posedge i_clk) begin
        if (w_mem_we && i_ctl_cmd.exec) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    assign w_used = r_acc + r_off;
    assign n_peak = (r_take_ok && (w_used > r_peak)) ? w_used : r_peak;
    assign o_dp_status.sum_done = (r_sum_idx == r_cur) && !r_sum_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_cur      <= '0;
            r_off      <= '0;
            r_total    <= '0;
            r_growths  <= '0;
            r_peak     <= '0;
            r_min      <= BYTE_BITS'(MIN_BLOCK_RESET);
            r_sum_idx  <= '0;
            r_sum_pend <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_min <= i_cfg_wr_data;
            if (i_ctl_cmd.exec) begin
                r_count    <= n_count;
                r_cur      <= n_cur;
                r_off      <= n_off;
                r_total    <= n_total;
                r_growths  <= n_growths;
                r_sum_idx  <= '0;
                r_sum_pend <= 1'b0;
            end else if (i_ctl_cmd.sum_step) begin
                // read issued here, data lands next cycle
                if (r_sum_idx != r_cur) begin
                    r_sum_idx  <= r_sum_idx + IDX_W'(1);
                    r_sum_pend <= 1'b1;
                end else begin
                    r_sum_pend <= 1'b0;
                end
            end
            if (i_ctl_cmd.load_out) r_peak <= n_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl_cmd.capture) begin
            r_cmd  <= i_command;
            r_size <= i_size_bytes;
            r_alog <= i_align_log2;
            r_mblk <= i_mark_block;
            r_moff <= i_mark_offset;
        end
        if (i_ctl_cmd.exec) begin
            r_res_status <= n_res_status;
            r_grant      <= n_grant;
            r_grew       <= n_grew;
            r_take_ok    <= n_take_ok;
            r_acc        <= '0;
        end else if (i_ctl_cmd.sum_step && r_sum_pend) begin
            r_acc <= r_acc + r_rd_data;
        end
        if (i_ctl_cmd.load_out) begin
            r_o_status  <= r_res_status;
            r_o_block   <= r_cur;
            r_o_grant   <= r_grant;
            r_o_grew    <= r_grew;
            r_o_used    <= w_used;
            r_o_peak    <= n_peak;
            r_o_cap     <= r_total;
            r_o_growths <= r_growths;
        end
    end

    assign o_status       = r_o_status;
    assign o_block_index  = r_o_block;
    assign o_grant_offset = r_o_grant;
    assign o_grew         = r_o_grew;
    assign o_used_sum     = r_o_used;
    assign o_high_water   = r_o_peak;
    assign o_capacity     = r_o_cap;
    assign o_growth_count = r_o_growths;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BLOCKS))
        else $error("block count beyond table depth");

    a_cur_in_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 && r_cur == '0) || (CW'(r_cur) < r_count))
        else $error("current block outside the chain");

    a_peak_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak <= r_total)
        else $error("high-water mark above capacity");

    a_growth_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_growths >= $past(r_growths)))
        else $error("growth count went backward");

endmodule

@@ tb/sv/multi_block_bump_allocator_top_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// multi_block_bump_allocator_top_tb
// Drives take, release, arena reset and no-op commands into the bump
// allocator under random idling on both sides and one long output stall,
// rewrites min_block_bytes between phases, and checks every result beat
// field by field against a cycle-free predictor of the arena state.
// ---------------------------------------------------------------------------
module multi_block_bump_allocator_top_tb;
    import mbba_pkg::*;

    localparam int NBLK = 8;
    localparam int BB   = 24;

    typedef logic [BB+1:0] t_wide;
    localparam t_wide BYTE_MASK = {2'b00, {BB{1'b1}}};

    typedef struct {
        t_cmd_code     command;
        logic [BB-1:0] size_bytes;
        logic [3:0]    align_log2;
        logic [2:0]    mark_block;
        logic [BB-1:0] mark_offset;
    } t_arena_cmd;

    typedef struct {
        t_status_code  status;
        logic [2:0]    block_index;
        logic [BB-1:0] grant_offset;
        logic          grew;
        logic [BB-1:0] used_sum;
        logic [BB-1:0] high_water;
        logic [BB-1:0] capacity;
        logic [31:0]   growth_count;
    } t_arena_reply;

    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          i_cfg_wr_en   = 1'b0;
    logic [BB-1:0] i_cfg_wr_data = '0;
    logic          i_valid       = 1'b0;
    logic [1:0]    i_command     = CMD_NOP;
    logic [BB-1:0] i_size_bytes  = '0;
    logic [3:0]    i_align_log2  = '0;
    logic [2:0]    i_mark_block  = '0;
    logic [BB-1:0] i_mark_offset = '0;
    logic          i_ready       = 1'b0;
    logic          o_ready;
    logic          o_valid;
    logic [1:0]    o_status;
    logic [2:0]    o_block_index;
    logic [BB-1:0] o_grant_offset;
    logic          o_grew;
    logic [BB-1:0] o_used_sum;
    logic [BB-1:0] o_high_water;
    logic [BB-1:0] o_capacity;
    logic [31:0]   o_growth_count;

    multi_block_bump_allocator_top #(
        .MAX_BLOCKS (NBLK),
        .BYTE_BITS  (BB)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_size_bytes   (i_size_bytes),
        .i_align_log2   (i_align_log2),
        .i_mark_block   (i_mark_block),
        .i_mark_offset  (i_mark_offset),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_block_index  (o_block_index),
        .o_grant_offset (o_grant_offset),
        .o_grew         (o_grew),
        .o_used_sum     (o_used_sum),
        .o_high_water   (o_high_water),
        .o_capacity     (o_capacity),
        .o_growth_count (o_growth_count)
    );

    // shadow arena
    logic [BB-1:0] blk_bytes [NBLK];
    logic [3:0]    blk_count;
    logic [2:0]    cur_blk;
    logic [BB-1:0] bump_ptr;
    logic [BB-1:0] total_cap;
    logic [31:0]   growths;
    logic [BB-1:0] peak_used;
    logic [BB-1:0] min_blk;

    t_arena_cmd   arena_cmds [$];
    t_arena_reply arena_replies_due [$];

    int mismatches   = 0;
    int replies_seen = 0;
    int idle_odds    = 0;  // 0 turns idling off on both sides
    int tx_gap       = 0;
    int rx_stall     = 0;
    bit hold_armed   = 1'b0;

    function automatic void arena_clear();
        for (int i = 0; i < NBLK; i++) begin
            blk_bytes[i] = '0;
        end
        blk_count = '0;
        cur_blk   = '0;
        bump_ptr  = '0;
        total_cap = '0;
        growths   = '0;
        peak_used = '0;
        min_blk   = BB'(MIN_BLOCK_RESET);
    endfunction

    function automatic t_wide arena_used();
        t_wide acc;
        acc = t_wide'(bump_ptr);
        for (int i = 0; i < NBLK; i++) begin
            if (i < cur_blk) acc = acc + t_wide'(blk_bytes[i]);
        end
        return acc;
    endfunction

    function automatic void note_peak();
        t_wide u;
        u = arena_used();
        if (u > t_wide'(peak_used)) peak_used = u[BB-1:0];
    endfunction

    function automatic t_arena_reply next_arena_reply(t_arena_cmd c);
        t_arena_reply r;
        t_wide        align;
        t_wide        at;
        t_wide        want;
        t_wide        u;
        logic         fitted;
        logic         mark_ok;
        r.status       = ST_OK;
        r.grant_offset = '0;
        r.grew         = 1'b0;
        case (c.command)
            CMD_TAKE: begin
                align  = t_wide'(1) << c.align_log2;
                fitted = 1'b0;
                if (blk_count > 0) begin
                    at = (t_wide'(bump_ptr) + align - t_wide'(1)) & ~(align - t_wide'(1));
                    if (at + t_wide'(c.size_bytes) <= t_wide'(blk_bytes[cur_blk])) begin
                        bump_ptr       = BB'(at + t_wide'(c.size_bytes));
                        r.grant_offset = at[BB-1:0];
                        fitted         = 1'b1;
                        note_peak();
                    end
                end
                if (!fitted) begin
                    want = t_wide'(c.size_bytes) + align;
                    if (t_wide'(total_cap) > want) want = t_wide'(total_cap);
                    if (t_wide'(min_blk) > want) want = t_wide'(min_blk);
                    if (blk_count >= NBLK) begin
                        r.status = ST_FULL;
                    end else if (want > BYTE_MASK ||
                                 t_wide'(total_cap) + want > BYTE_MASK) begin
                        r.status = ST_OVERFLOW;
                    end else begin
                        blk_bytes[blk_count[2:0]] = want[BB-1:0];
                        cur_blk   = blk_count[2:0];
                        blk_count = blk_count + 4'd1;
                        total_cap = total_cap + want[BB-1:0];
                        if (growths != 32'hFFFF_FFFF) growths = growths + 32'd1;
                        bump_ptr  = c.size_bytes;
                        r.grew    = 1'b1;
                        note_peak();
                    end
                end
            end
            CMD_RELEASE: begin
                if (blk_count == 0) begin
                    mark_ok = (c.mark_block == 0) && (c.mark_offset == 0);
                end else begin
                    mark_ok = ({1'b0, c.mark_block} < blk_count) &&
                              (c.mark_offset <= blk_bytes[c.mark_block]);
                end
                if (mark_ok) begin
                    cur_blk  = c.mark_block;
                    bump_ptr = c.mark_offset;
                end else begin
                    r.status = ST_BAD_MARK;
                end
            end
            CMD_RESET: begin
                cur_blk  = '0;
                bump_ptr = '0;
                // a chain of several blocks collapses into one
                if (blk_count > 1) begin
                    blk_bytes[0] = total_cap;
                    blk_count    = 4'd1;
                end
            end
            default: begin
            end
        endcase
        u              = arena_used();
        r.block_index  = cur_blk;
        r.used_sum     = u[BB-1:0];
        r.high_water   = peak_used;
        r.capacity     = total_cap;
        r.growth_count = growths;
        return r;
    endfunction

    function automatic t_arena_cmd make_cmd(t_cmd_code cmd, logic [BB-1:0] size,
                                            logic [3:0] alog, logic [2:0] mblk,
                                            logic [BB-1:0] moff);
        t_arena_cmd c;
        c.command     = cmd;
        c.size_bytes  = size;
        c.align_log2  = alog;
        c.mark_block  = mblk;
        c.mark_offset = moff;
        return c;
    endfunction

    function automatic void queue_cmd(t_arena_cmd c);
        arena_cmds.insert(arena_cmds.size(), c);
    endfunction

    // mostly small takes and near marks so the chain keeps fitting and
    // unwinding; the rest are wide values that land in the error paths
    function automatic t_arena_cmd random_cmd();
        t_arena_cmd c;
        int         pick;
        int         sel;
        c.size_bytes  = BB'($urandom);
        c.align_log2  = 4'($urandom);
        c.mark_block  = 3'($urandom);
        c.mark_offset = BB'($urandom);
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 19);
        if (pick < 62) begin
            c.command = CMD_TAKE;
            if (sel < 12) begin
                c.size_bytes = BB'($urandom_range(0, 63));
                c.align_log2 = 4'($urandom_range(0, 4));
            end else if (sel < 17) begin
                c.size_bytes = BB'($urandom_range(0, 4095));
                c.align_log2 = 4'($urandom_range(0, 12));
            end else if (sel < 19) begin
                c.size_bytes = BB'($urandom_range(0, 262143));
                c.align_log2 = 4'($urandom_range(0, 15));
            end
        end else if (pick < 88) begin
            c.command = CMD_RELEASE;
            if (sel < 17) c.mark_offset = BB'($urandom_range(0, 255));
        end else if (pick < 96) begin
            c.command = CMD_RESET;
        end else begin
            c.command = CMD_NOP;
        end
        return c;
    endfunction

    // checked between edges so the driver's updates have settled
    task automatic wait_idle();
        while (arena_cmds.size() != 0 || i_valid || arena_replies_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_min_block(logic [BB-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        min_blk = value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_random_phase(logic [BB-1:0] min_bytes, int odds, int count);
        wait_idle();
        write_min_block(min_bytes);
        idle_odds = odds;
        for (int n = 0; n < count; n++) begin
            queue_cmd(random_cmd());
        end
    endtask

    task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // command side: a beat is taken at an edge with valid and ready both high
    always @(posedge i_clk) begin : cmd_driver
        t_arena_cmd c;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                c = make_cmd(i_command, i_size_bytes, i_align_log2, i_mark_block,
                             i_mark_offset);
                arena_replies_due.insert(arena_replies_due.size(), next_arena_reply(c));
            end
            if (tx_gap > 0) begin
                tx_gap--;
                i_valid <= 1'b0;
            end else if (arena_cmds.size() != 0) begin
                c = arena_cmds.pop_front();
                i_command     <= c.command;
                i_size_bytes  <= c.size_bytes;
                i_align_log2  <= c.align_log2;
                i_mark_block  <= c.mark_block;
                i_mark_offset <= c.mark_offset;
                i_valid       <= 1'b1;
                if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
                    tx_gap = $urandom_range(1, 19);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result side
    always @(posedge i_clk) begin : reply_monitor
        t_arena_reply due;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                replies_seen++;
                if (arena_replies_due.size() == 0) begin
                    $error("result beat with no command outstanding");
                    mismatches++;
                end else begin
                    due = arena_replies_due.pop_front();
                    compare_field("status", due.status, o_status);
                    compare_field("block_index", due.block_index, o_block_index);
                    compare_field("grant_offset", due.grant_offset, o_grant_offset);
                    compare_field("grew", due.grew, o_grew);
                    compare_field("used_sum", due.used_sum, o_used_sum);
                    compare_field("high_water", due.high_water, o_high_water);
                    compare_field("capacity", due.capacity, o_capacity);
                    compare_field("growth_count", due.growth_count, o_growth_count);
                end
            end
            // one long hold so the block backs up and stalls its input
            if (hold_armed && replies_seen >= 80) begin
                hold_armed = 1'b0;
                rx_stall   = 400;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                i_ready <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
                rx_stall = $urandom_range(0, 18);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        #1000000;
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        int drain_cycles;
        arena_clear();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_min_block(BB'(1));
        idle_odds = 5;
        // empty arena: only the zero mark is good
        queue_cmd(make_cmd(CMD_RELEASE, '0, 4'd0, 3'd0, '0));
        queue_cmd(make_cmd(CMD_RELEASE, '0, 4'd0, 3'd1, '0));
        queue_cmd(make_cmd(CMD_RELEASE, '0, 4'd0, 3'd0, 24'd5));
        queue_cmd(make_cmd(CMD_RESET, '0, 4'd0, 3'd0, '0));
        queue_cmd(make_cmd(CMD_NOP, '1, 4'hF, 3'd7, '1));
        // new block larger than the byte range
        queue_cmd(make_cmd(CMD_TAKE, '1, 4'd15, 3'd0, '0));
        queue_cmd(make_cmd(CMD_TAKE, '0, 4'd0, 3'd0, '0));
        queue_cmd(make_cmd(CMD_TAKE, 24'd1, 4'd0, 3'd0, '0));
        queue_cmd(make_cmd(CMD_TAKE, 24'd0, 4'd0, 3'd0, '0));
        queue_cmd(make_cmd(CMD_TAKE, 24'd3, 4'd2, 3'd0, '0));
        // back, forward to the block end, past it, beyond the chain
        queue_cmd(make_cmd(CMD_RELEASE, '0, 4'd0, 3'd0, 24'd1));
        queue_cmd(make_cmd(CMD_RELEASE, '0, 4'd0, 3'd1, 24'd7));
        queue_cmd(make_cmd(CMD_RELEASE, '0, 4'd0, 3'd1, 24'd8));
        queue_cmd(make_cmd(CMD_RELEASE, '0, 4'd0, 3'd2, 24'd0));
        // growth after a release still appends at the end
        queue_cmd(make_cmd(CMD_RELEASE, '0, 4'd0, 3'd0, 24'd0));
        queue_cmd(make_cmd(CMD_TAKE, 24'd2, 4'd0, 3'd0, '0));
        queue_cmd(make_cmd(CMD_RESET, '0, 4'd0, 3'd0, '0));
        queue_cmd(make_cmd(CMD_TAKE, 24'd0, 4'd12, 3'd0, '0));
        queue_cmd(make_cmd(CMD_TAKE, 24'd16, 4'd15, 3'd0, '0));
        // fill the block table, then one more take that finds it full
        queue_cmd(make_cmd(CMD_TAKE, 24'd17, 4'd0, 3'd0, '0));
        queue_cmd(make_cmd(CMD_TAKE, 24'd19, 4'd0, 3'd0, '0));
        queue_cmd(make_cmd(CMD_TAKE, 24'd35, 4'd0, 3'd0, '0));
        queue_cmd(make_cmd(CMD_TAKE, 24'd69, 4'd0, 3'd0, '0));
        queue_cmd(make_cmd(CMD_TAKE, 24'd137, 4'd0, 3'd0, '0));
        queue_cmd(make_cmd(CMD_TAKE, 24'd273, 4'd0, 3'd0, '0));
        queue_cmd(make_cmd(CMD_TAKE, 24'd545, 4'd0, 3'd0, '0));
        queue_cmd(make_cmd(CMD_TAKE, 24'd2000, 4'd0, 3'd0, '0));

        hold_armed = 1'b1;
        run_random_phase(BB'(MIN_BLOCK_RESET), 4, 450);
        run_random_phase(BB'($urandom_range(2, 4095)), 0, 450);
        run_random_phase(BB'($urandom_range(4096, 65535)), 10, 300);
        run_random_phase('1, 0, 200);

        while (arena_cmds.size() != 0 || i_valid) @(negedge i_clk);
        drain_cycles = 0;
        while (arena_replies_due.size() != 0 && drain_cycles < 2000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (20) @(posedge i_clk);
        if (arena_replies_due.size() != 0) begin
            $error("%0d result beats never arrived", arena_replies_due.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
